/* src/token_bucket_reserve_refund_core_defines.svh */
// ----------------------------------------------------------------------------
// Token bucket core assertion macros
// Shared concurrent assertion helpers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_RESERVE_REFUND_CORE_DEFINES_SVH
`define TOKEN_BUCKET_RESERVE_REFUND_CORE_DEFINES_SVH

// Checked only while the block is out of reset.
`define TBRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked at every rising edge of clk_i, also during reset.
`define TBRR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

/* src/tbrr_pkg.sv */
// ----------------------------------------------------------------------------
// Token bucket package
// Field widths, opcodes and the item types of the token bucket core.
// ----------------------------------------------------------------------------
package tbrr_pkg;

  localparam int CAP_W     = 24;
  localparam int AMOUNT_W  = 16;
  localparam int USED_W    = 17;
  localparam int CNT_W     = 2;
  localparam int CAP_RESET = 60000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RESERVE = 2'd1,
    OP_SETTLE  = 2'd2
  } opcode_e;

  typedef logic [CAP_W-1:0] cap_t;

  typedef struct packed {
    opcode_e               opcode;
    logic [AMOUNT_W-1:0]   amount;
    logic [USED_W-1:0]     used_tokens;
    logic                  succeeded;
  } in_item_t;

  typedef struct packed {
    logic                  granted;
    logic [AMOUNT_W-1:0]   refund_amount;
    logic [CAP_W-1:0]      whole_tokens;
  } out_item_t;

endpackage

/* src/tbrr_chan_if.sv */
// ----------------------------------------------------------------------------
// Token bucket channel interface
// Valid/ready channel; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tbrr_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* src/token_bucket_reserve_refund_core.sv */
// An item's result is registered in the output register in the cycle after its transfer.
// Throughput: one item per cycle while not busy and the result is taken; the level registers are updated per item.
// A capacity write starts a split of the capacity into whole tokens and a fraction
// per tick, first the whole part, then the fraction; items and writes wait meanwhile.
// Reset (rst_ni low, asynchronous) sets a capacity of 60000 with the bucket full.
// ----------------------------------------------------------------------------
// Token bucket reserve/refund core
// Token bucket with tick refill, reserve and settle. The level is held as
// whole tokens plus a fraction in units of 1/(60*TICKS_PER_SECOND) of a token.
// ----------------------------------------------------------------------------
`include "token_bucket_reserve_refund_core_defines.svh"

module token_bucket_reserve_refund_core #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbrr_chan_if.sink   cfg_i,
  tbrr_chan_if.sink   item_i,
  tbrr_chan_if.source result_o
);

  localparam int CAP_W   = tbrr_pkg::CAP_W;
  localparam int AMT_W   = tbrr_pkg::AMOUNT_W;
  localparam int USED_W  = tbrr_pkg::USED_W;
  localparam int CNT_W   = tbrr_pkg::CNT_W;
  localparam int SCALE   = 60 * TICKS_PER_SECOND;
  localparam int SCALE_W = $clog2(SCALE);
  localparam int SHIFT   = CAP_W + SCALE_W;

  localparam logic [SCALE_W:0]   SCALE_V   = (SCALE_W+1)'(SCALE);
  localparam logic [CAP_W-1:0]   CAP_RST   = CAP_W'(tbrr_pkg::CAP_RESET);
  localparam logic [CAP_W-1:0]   CW_RST    = CAP_W'(tbrr_pkg::CAP_RESET / SCALE);
  localparam logic [SCALE_W-1:0] CF_RST    = SCALE_W'(tbrr_pkg::CAP_RESET % SCALE);
  localparam logic [CNT_W-1:0]   DIV_STEPS = CNT_W'(2);
  localparam logic [CAP_W:0]     RECIP     =
    (CAP_W+1)'(((64'd1 << SHIFT) + 64'(SCALE) - 64'd1) / 64'(SCALE));

  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [CAP_W-1:0]   whole_q, whole_d;
  logic [SCALE_W-1:0] frac_q, frac_d;
  logic [CAP_W-1:0]   cw_q, cw_d;
  logic [SCALE_W-1:0] cf_q, cf_d;
  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  tbrr_pkg::out_item_t out_q, out_d;

  tbrr_pkg::in_item_t item;
  logic               item_xfer;
  logic               cfg_xfer;
  logic [2*CAP_W:0]   recip_prod;
  logic [CAP_W-1:0]   quot;
  logic [SHIFT-1:0]   back_prod;
  logic [SCALE_W-1:0] frem;
  logic [SCALE_W:0]   fsum;
  logic               carry;
  logic [SCALE_W-1:0] fnew;
  logic [CAP_W:0]     tick_sum;
  logic [CAP_W:0]     refund_sum;
  logic [AMT_W-1:0]   refund;
  logic               level_ok;
  logic               split_start;
  logic               res_both;

  assign item      = item_i.data;
  assign cfg_i.ready  = !busy_q;
  assign item_i.ready = !busy_q && (!out_valid_q || result_o.ready);
  assign cfg_xfer  = cfg_i.valid && cfg_i.ready;
  assign item_xfer = item_i.valid && item_i.ready;

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // Capacity split by the tick scale with a reciprocal multiply.
  assign recip_prod = (2*CAP_W+1)'(cap_q) * (2*CAP_W+1)'(RECIP);
  assign quot       = CAP_W'(recip_prod >> SHIFT);
  assign back_prod  = SHIFT'(cw_q) * SHIFT'(SCALE);
  assign frem       = SCALE_W'(cap_q - back_prod[CAP_W-1:0]);

  // Tick refill: add the whole and fractional parts with one carry.
  assign fsum     = {1'b0, frac_q} + {1'b0, cf_q};
  assign carry    = (fsum >= SCALE_V);
  assign fnew     = carry ? SCALE_W'(fsum - SCALE_V) : fsum[SCALE_W-1:0];
  assign tick_sum = {1'b0, whole_q} + {1'b0, cw_q} + {{CAP_W{1'b0}}, carry};

  always_comb begin
    if (item.amount == '0) begin
      refund = '0;
    end else if (item.succeeded) begin
      refund = ({1'b0, item.amount} > item.used_tokens)
             ? AMT_W'({1'b0, item.amount} - item.used_tokens) : '0;
    end else begin
      refund = item.amount;
    end
  end

  assign refund_sum = {1'b0, whole_q} + {{(CAP_W+1-AMT_W){1'b0}}, refund};

  always_comb begin
    cap_d       = cap_q;
    whole_d     = whole_q;
    frac_d      = frac_q;
    cw_d        = cw_q;
    cf_d        = cf_q;
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == DIV_STEPS) begin
        cw_d = quot;
      end else begin
        cf_d   = frem;
        busy_d = 1'b0;
      end
    end

    if (cfg_xfer) begin
      cap_d   = cfg_i.data;
      whole_d = cfg_i.data;
      frac_d  = '0;
      busy_d  = 1'b1;
      cnt_d   = DIV_STEPS;
    end

    if (item_xfer) begin
      out_d.granted       = 1'b0;
      out_d.refund_amount = '0;
      unique case (item.opcode)
        tbrr_pkg::OP_TICK: begin
          if (tick_sum >= {1'b0, cap_q}) begin
            whole_d = cap_q;
            frac_d  = '0;
          end else begin
            whole_d = tick_sum[CAP_W-1:0];
            frac_d  = fnew;
          end
        end
        tbrr_pkg::OP_RESERVE: begin
          if (whole_q >= CAP_W'(item.amount)) begin
            whole_d       = whole_q - CAP_W'(item.amount);
            out_d.granted = 1'b1;
          end
        end
        tbrr_pkg::OP_SETTLE: begin
          out_d.refund_amount = refund;
          if (refund != '0) begin
            if (refund_sum >= {1'b0, cap_q}) begin
              whole_d = cap_q;
              frac_d  = '0;
            end else begin
              whole_d = refund_sum[CAP_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
      out_d.whole_tokens = whole_d;
      out_valid_d        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RST;
      whole_q     <= CAP_RST;
      frac_q      <= '0;
      cw_q        <= CW_RST;
      cf_q        <= CF_RST;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      whole_q     <= whole_d;
      frac_q      <= frac_d;
      cw_q        <= cw_d;
      cf_q        <= cf_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign level_ok    = (whole_q < cap_q) || ((whole_q == cap_q) && (frac_q == '0));
  assign split_start = busy_q && (whole_q == cap_q) && (cnt_q == DIV_STEPS);
  assign res_both    = out_q.granted && (out_q.refund_amount != '0);

  `TBRR_ASSERT(a_level_within_cap, level_ok, "bucket level above capacity")
  `TBRR_ASSERT(a_frac_below_scale, (SCALE_W+1)'(frac_q) < SCALE_V, "fraction not below one token")
  `TBRR_ASSERT(a_cfg_starts_split, cfg_xfer |=> split_start, "capacity write did not refill")
  `TBRR_ASSERT(a_result_exclusive, out_valid_q |-> !res_both, "grant and refund in one result")

endmodule
